@@ rtl/qfas_pkg.sv @@
package qfas_pkg;

  localparam int BIAS          = 16383;
  localparam int FAR_LIMIT     = 110;
  localparam int MUL_ZERO_SUM  = 16271;
  localparam int MUL_INF_SUM   = 49150;
  localparam int EXP_OVF       = 32767;

  localparam logic [14:0] EXP_MAX  = 15'h7FFF;
  localparam logic [1:0]  OP_SUB   = 2'd1;
  localparam int          OP_MUL_BIT = 1;

  typedef logic [112:0]        mant_t;
  typedef logic signed [17:0]  sexp_t;

  function automatic logic [6:0] lzc113(input mant_t m);
    logic [6:0] lz;
    lz = 7'd113;
    for (int i = 0; i < 113; i++) begin
      if (m[i]) begin
        lz = 7'(112 - i);
      end
    end
    return lz;
  endfunction

endpackage

@@ rtl/qfas_in_if.sv @@
interface qfas_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] a_high;
  logic [63:0] a_low;
  logic [63:0] b_high;
  logic [63:0] b_low;

  modport source (output valid, operation, a_high, a_low, b_high, b_low, input ready);
  modport sink   (input valid, operation, a_high, a_low, b_high, b_low, output ready);
endinterface

@@ rtl/qfas_out_if.sv @@
interface qfas_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

@@ rtl/qfas_mul.sv @@
module qfas_mul import qfas_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  mant_t        x,
  input  mant_t        y,
  output logic [113:0] p
);

  logic [31:0]  xl [4];
  logic [31:0]  yl [4];
  logic [63:0]  pp_r [4][4];
  logic [160:0] row_nxt [4];
  logic [160:0] row_r [4];
  logic [193:0] s01_nxt, s23_nxt, s01_r, s23_r;
  logic [257:0] total;

  always_comb begin
    xl[0] = x[31:0];
    xl[1] = x[63:32];
    xl[2] = x[95:64];
    xl[3] = {15'b0, x[112:96]};
    yl[0] = y[31:0];
    yl[1] = y[63:32];
    yl[2] = y[95:64];
    yl[3] = {15'b0, y[112:96]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pp_r[i][j] <= xl[i] * yl[j];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      row_nxt[i] = {33'b0, pp_r[i][2], pp_r[i][0]} + {1'b0, pp_r[i][3], pp_r[i][1], 32'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        row_r[i] <= row_nxt[i];
      end
    end
  end

  assign s01_nxt = {33'b0, row_r[0]} + {1'b0, row_r[1], 32'b0};
  assign s23_nxt = {33'b0, row_r[2]} + {1'b0, row_r[3], 32'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      s01_r <= s01_nxt;
      s23_r <= s23_nxt;
    end
  end

  assign total = {64'b0, s01_r} + {s23_r, 64'b0};
  assign p     = total[225:112];

endmodule

@@ rtl/quad_float_add_sub_mul_top.sv @@
// Channel   Direction  Payload
// in_if     sink       operation, a_high, a_low, b_high, b_low
// out_if    source     result_high, result_low
//
// One item enters per cycle whenever the output register is empty or taken.
// The seven register stages are unpack, align/partial products, add/row sums,
// product sums, carry fix, leading-zero count, normalize/pack.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the stage valid bits only.
module quad_float_add_sub_mul_top import qfas_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  qfas_in_if.sink    in_if,
  qfas_out_if.source out_if
);

  logic en;
  logic [6:0] v_r;

  // stage 1 inputs
  logic [63:0] ah, al, bh, bl, xh, xl, yh, yl;
  logic [14:0] ea, eb, ex, ey, d_full;
  logic        is_mul, swap, fa, fb, nan_a, nan_b, inf_a, inf_b, za, zb, smul;
  logic [16:0] esum;
  logic        fixed_nxt;
  logic [127:0] fval_nxt;
  sexp_t       exb_nxt;

  logic        mul1_r, fixed1_r, sign1_r, same1_r;
  logic [127:0] fval1_r;
  sexp_t       exb1_r;
  mant_t       mx1_r, my1_r;
  logic [6:0]  d1_r;

  logic        mul2_r, fixed2_r, sign2_r, same2_r;
  logic [127:0] fval2_r;
  sexp_t       exb2_r;
  mant_t       mx2_r, f2_r;

  logic        lt;
  logic [113:0] r_nxt;
  logic        mul3_r, fixed3_r, sign3_r;
  logic [127:0] fval3_r;
  sexp_t       exb3_r;
  logic [113:0] r3_r;

  logic        mul4_r, fixed4_r, sign4_r;
  logic [127:0] fval4_r;
  sexp_t       exb4_r;
  logic [113:0] r4_r;

  logic [113:0] p, m_pre;
  logic        fixed5_r, sign5_r;
  logic [127:0] fval5_r;
  sexp_t       exb5_r;
  mant_t       m5_r;

  logic        fixed6_r, sign6_r;
  logic [127:0] fval6_r;
  sexp_t       exb6_r;
  mant_t       m6_r;
  logic [6:0]  lz6_r;

  sexp_t       lz_s, bf;
  mant_t       msh;
  logic        under, over;
  logic [127:0] res_nxt, res_r;

  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_if.valid};
    end
  end

  always_comb begin
    is_mul = in_if.operation[OP_MUL_BIT];
    ah     = in_if.a_high;
    al     = in_if.a_low;
    bh     = in_if.b_high ^ {(!is_mul && in_if.operation == OP_SUB), 63'b0};
    bl     = in_if.b_low;
    ea     = ah[62:48];
    eb     = bh[62:48];
    swap   = eb > ea;
    xh     = swap ? bh : ah;
    xl     = swap ? bl : al;
    yh     = swap ? ah : bh;
    yl     = swap ? al : bl;
    ex     = xh[62:48];
    ey     = yh[62:48];
    d_full = ex - ey;
    fa     = |{ah[47:0], al};
    fb     = |{bh[47:0], bl};
    inf_a  = ea == EXP_MAX;
    inf_b  = eb == EXP_MAX;
    nan_a  = inf_a && fa;
    nan_b  = inf_b && fb;
    za     = ea == 15'd0 && !fa;
    zb     = eb == 15'd0 && !fb;
    smul   = ah[63] ^ bh[63];
    esum   = {2'b0, ea} + {2'b0, eb};
    fixed_nxt = 1'b0;
    fval_nxt  = {xh, xl};
    exb_nxt   = sexp_t'({3'b0, ex});
    if (is_mul) begin
      exb_nxt   = sexp_t'({1'b0, esum}) - sexp_t'(BIAS);
      fixed_nxt = 1'b1;
      if (inf_a || inf_b) begin
        if (nan_a || nan_b || (!(inf_a && inf_b) && (za || zb))) begin
          fval_nxt = {smul, EXP_MAX, 48'h8000_0000_0000, 64'b0};
        end else begin
          fval_nxt = {smul, EXP_MAX, 112'b0};
        end
      end else if (za || zb || esum <= 17'(MUL_ZERO_SUM)) begin
        fval_nxt = {smul, 127'b0};
      end else if (esum >= 17'(MUL_INF_SUM)) begin
        fval_nxt = {smul, EXP_MAX, 112'b0};
      end else begin
        fixed_nxt = 1'b0;
      end
    end else begin
      fixed_nxt = d_full > 15'(FAR_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul1_r   <= is_mul;
      fixed1_r <= fixed_nxt;
      fval1_r  <= fval_nxt;
      sign1_r  <= is_mul ? smul : xh[63];
      same1_r  <= xh[63] == yh[63];
      exb1_r   <= exb_nxt;
      mx1_r    <= {|ex, xh[47:0], xl};
      my1_r    <= {|ey, yh[47:0], yl};
      d1_r     <= d_full[6:0];
    end
  end

  qfas_mul u_mul (
    .clk (clk),
    .en  (en),
    .x   (mx1_r),
    .y   (my1_r),
    .p   (p)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      mul2_r   <= mul1_r;
      fixed2_r <= fixed1_r;
      fval2_r  <= fval1_r;
      sign2_r  <= sign1_r;
      same2_r  <= same1_r;
      exb2_r   <= exb1_r;
      mx2_r    <= mx1_r;
      f2_r     <= my1_r >> d1_r;
    end
  end

  always_comb begin
    lt = mx2_r < f2_r;
    if (same2_r) begin
      r_nxt = {1'b0, mx2_r} + {1'b0, f2_r};
    end else if (lt) begin
      r_nxt = {1'b0, f2_r - mx2_r};
    end else begin
      r_nxt = {1'b0, mx2_r - f2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul3_r   <= mul2_r;
      fixed3_r <= fixed2_r;
      fval3_r  <= fval2_r;
      sign3_r  <= sign2_r ^ (!mul2_r && !same2_r && lt);
      exb3_r   <= exb2_r;
      r3_r     <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul4_r   <= mul3_r;
      fixed4_r <= fixed3_r;
      fval4_r  <= fval3_r;
      sign4_r  <= sign3_r;
      exb4_r   <= exb3_r;
      r4_r     <= r3_r;
    end
  end

  assign m_pre = mul4_r ? p : r4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fixed5_r <= fixed4_r;
      fval5_r  <= fval4_r;
      sign5_r  <= sign4_r;
      exb5_r   <= m_pre[113] ? exb4_r + sexp_t'(1) : exb4_r;
      m5_r     <= m_pre[113] ? m_pre[113:1] : m_pre[112:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fixed6_r <= fixed5_r;
      fval6_r  <= fval5_r;
      sign6_r  <= sign5_r;
      exb6_r   <= exb5_r;
      m6_r     <= m5_r;
      lz6_r    <= lzc113(m5_r);
    end
  end

  always_comb begin
    lz_s  = {11'b0, lz6_r};
    bf    = exb6_r - lz_s;
    under = (exb6_r <= 0) || (lz_s >= exb6_r) || (m6_r == '0);
    over  = bf >= EXP_OVF;
    msh   = m6_r << lz6_r;
    if (fixed6_r) begin
      res_nxt = fval6_r;
    end else if (under) begin
      res_nxt = {sign6_r, 127'b0};
    end else if (over) begin
      res_nxt = {sign6_r, EXP_MAX, 112'b0};
    end else begin
      res_nxt = {sign6_r, bf[14:0], msh[111:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid       = v_r[6];
  assign out_if.result_high = res_r[127:64];
  assign out_if.result_low  = res_r[63:0];

endmodule
